// ===== design/utf8dc_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8dc_pkg
// Types and constants shared by the UTF-8 decoder and digit classifier.
// ----------------------------------------------------------------------------
package utf8dc_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  localparam logic [20:0] ZeroReset   = 21'd48;
  localparam logic [20:0] AsciiZero   = 21'h00030;
  localparam logic [20:0] AsciiNine   = 21'h00039;
  localparam logic [20:0] Min3Byte    = 21'h00800;
  localparam logic [20:0] Min4Byte    = 21'h10000;
  localparam logic [20:0] MaxScalar   = 21'h10FFFF;
  localparam logic [20:0] SurrLow     = 21'h0D800;
  localparam logic [20:0] SurrHigh    = 21'h0DFFF;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StBadLead = 3'd1,
    StBadCont = 3'd2,
    StRange   = 3'd3,
    StTrunc   = 3'd4
  } status_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] byte_in;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    status_e     status;
    logic [2:0]  byte_count;
    logic        is_digit;
    logic [3:0]  digit_value;
    logic        last;
  } out_t;

  // One decoded input: an optional broken-sequence error, then an optional main word.
  typedef struct packed {
    logic        first_v;
    logic [2:0]  first_count;
    logic        main_v;
    logic [20:0] main_cp;
    status_e     main_status;
    logic [2:0]  main_count;
  } rec_t;

  function automatic logic is_scalar(logic [20:0] v);
    return (v <= MaxScalar) && !((v >= SurrLow) && (v <= SurrHigh));
  endfunction

endpackage

// ===== design/utf8_decoder_digit_classifier.sv =====
// ----------------------------------------------------------------------------
// utf8_decoder_digit_classifier
// UTF-8 decoder with decimal digit classification for ASCII and a locale zero.
// ----------------------------------------------------------------------------
// Channel   Ports                         Handshake
// input     item_i (mode, byte_in)        push / full, taken on push && !full
// result    result_o (code_point .. last) empty / pop, taken on pop && !empty
// config    cfg_wdata_i (zero_code_point) cfg_we_i, taken every enabled edge
//
// While not full, a byte is taken per cycle; the tracker updates its state in
// the accepting cycle and queues one record per byte that yields words.
// A record with a broken-sequence error and a new word yields two output
// words from the result stage, one word per cycle while the consumer pops.
// Each word is first queued as a record, then registered in the result stage.
// Reset clears the sequence state, the queue and the output valid flag.
// Output stalls back up through the record queue until full asserts.
// ----------------------------------------------------------------------------
module utf8_decoder_digit_classifier (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  utf8dc_pkg::in_t   item_i,
  output logic              empty,
  input  logic              pop,
  output utf8dc_pkg::out_t  result_o,
  input  logic              cfg_we_i,
  input  logic [20:0]       cfg_wdata_i
);

  logic              rec_valid;
  utf8dc_pkg::rec_t  rec_in, rec_head;
  logic              rec_empty, rec_pop;

  utf8dc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (push && !full),
    .item_i      (item_i),
    .rec_valid_o (rec_valid),
    .rec_o       (rec_in)
  );

  utf8dc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_valid),
    .data_i  (rec_in),
    .full_o  (full),
    .pop_i   (rec_pop),
    .empty_o (rec_empty),
    .data_o  (rec_head)
  );

  utf8dc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rec_empty_i (rec_empty),
    .rec_i       (rec_head),
    .rec_pop_o   (rec_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

// ===== design/utf8dc_front.sv =====
// ----------------------------------------------------------------------------
// utf8dc_front
// Sequence tracker: consumes bytes and end-of-text marks, emits decode records.
// ----------------------------------------------------------------------------
module utf8dc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  utf8dc_pkg::in_t   item_i,
  output logic              rec_valid_o,
  output utf8dc_pkg::rec_t  rec_o
);

  logic [2:0]  exp_q, exp_d;
  logic [2:0]  taken_q, taken_d;
  logic [20:0] pv_q, pv_d;

  logic [7:0]  b;
  logic        use_lead;
  logic [20:0] pv_new;
  logic [2:0]  taken_new;
  logic        bad;

  assign b         = item_i.byte_in;
  assign pv_new    = {pv_q[14:0], b[5:0]};
  assign taken_new = taken_q + 3'd1;

  always_comb begin
    exp_d    = exp_q;
    taken_d  = taken_q;
    pv_d     = pv_q;
    rec_o    = '0;
    use_lead = 1'b0;
    bad      = 1'b0;
    if (valid_i) begin
      if (item_i.mode) begin
        if (exp_q != 3'd0) begin
          rec_o.main_v      = 1'b1;
          rec_o.main_status = utf8dc_pkg::StTrunc;
          rec_o.main_count  = taken_q;
        end
        exp_d   = '0;
        taken_d = '0;
        pv_d    = '0;
      end else if (exp_q == 3'd0) begin
        use_lead = 1'b1;
      end else if (b[7:6] == 2'b10) begin
        if (taken_new >= exp_q) begin
          bad = ((exp_q == 3'd3) && (pv_new < utf8dc_pkg::Min3Byte)) ||
                ((exp_q == 3'd4) && (pv_new < utf8dc_pkg::Min4Byte)) ||
                !utf8dc_pkg::is_scalar(pv_new);
          rec_o.main_v      = 1'b1;
          rec_o.main_status = bad ? utf8dc_pkg::StRange : utf8dc_pkg::StOk;
          rec_o.main_cp     = bad ? '0 : pv_new;
          rec_o.main_count  = exp_q;
          exp_d   = '0;
          taken_d = '0;
          pv_d    = '0;
        end else begin
          taken_d = taken_new;
          pv_d    = pv_new;
        end
      end else begin
        rec_o.first_v     = 1'b1;
        rec_o.first_count = taken_q;
        exp_d    = '0;
        taken_d  = '0;
        pv_d     = '0;
        use_lead = 1'b1;
      end

      if (use_lead) begin
        if (b[7] == 1'b0) begin
          rec_o.main_v      = 1'b1;
          rec_o.main_status = utf8dc_pkg::StOk;
          rec_o.main_cp     = {13'd0, b};
          rec_o.main_count  = 3'd1;
        end else if (b >= 8'hC2 && b < 8'hE0) begin
          exp_d   = 3'd2;
          taken_d = 3'd1;
          pv_d    = {16'd0, b[4:0]};
        end else if (b >= 8'hE0 && b < 8'hF0) begin
          exp_d   = 3'd3;
          taken_d = 3'd1;
          pv_d    = {17'd0, b[3:0]};
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          exp_d   = 3'd4;
          taken_d = 3'd1;
          pv_d    = {18'd0, b[2:0]};
        end else begin
          rec_o.main_v      = 1'b1;
          rec_o.main_status = utf8dc_pkg::StBadLead;
          rec_o.main_count  = 3'd1;
        end
      end
    end
    rec_valid_o = rec_o.first_v | rec_o.main_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= '0;
      taken_q <= '0;
      pv_q    <= '0;
    end else begin
      exp_q   <= exp_d;
      taken_q <= taken_d;
      pv_q    <= pv_d;
    end
  end

endmodule

// ===== design/utf8dc_fifo.sv =====
// ----------------------------------------------------------------------------
// utf8dc_fifo
// Short record queue between the sequence tracker and the result stage.
// ----------------------------------------------------------------------------
module utf8dc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  utf8dc_pkg::rec_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output utf8dc_pkg::rec_t  data_o
);

  utf8dc_pkg::rec_t                 mem_q [utf8dc_pkg::FifoDepth];
  logic [utf8dc_pkg::FifoAw-1:0]    wptr_q, rptr_q;
  logic [utf8dc_pkg::FifoCw-1:0]    cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == utf8dc_pkg::FifoCw'(utf8dc_pkg::FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == utf8dc_pkg::FifoAw'(utf8dc_pkg::FifoDepth - 1)) ? '0
                                                                            : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == utf8dc_pkg::FifoAw'(utf8dc_pkg::FifoDepth - 1)) ? '0
                                                                            : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/utf8dc_back.sv =====
// ----------------------------------------------------------------------------
// utf8dc_back
// Result stage: splits records into words, classifies digits, holds output.
// ----------------------------------------------------------------------------
module utf8dc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [20:0]       cfg_wdata_i,
  input  logic              rec_empty_i,
  input  utf8dc_pkg::rec_t  rec_i,
  output logic              rec_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output utf8dc_pkg::out_t  result_o
);

  logic [20:0]       zero_q;
  logic              phase_q, phase_d;
  logic              valid_q, valid_d;
  utf8dc_pkg::out_t  out_q, out_d;

  logic              sel_first, load;
  logic [20:0]       diff;

  assign sel_first = rec_i.first_v && !phase_q;
  assign load      = !rec_empty_i && (!valid_q || pop_i);
  assign diff      = rec_i.main_cp - zero_q;

  always_comb begin
    out_d     = '0;
    phase_d   = phase_q;
    rec_pop_o = 1'b0;
    valid_d   = valid_q && !pop_i;
    if (sel_first) begin
      out_d.status     = utf8dc_pkg::StBadCont;
      out_d.byte_count = rec_i.first_count;
      out_d.last       = !rec_i.main_v;
    end else begin
      out_d.code_point = rec_i.main_cp;
      out_d.status     = rec_i.main_status;
      out_d.byte_count = rec_i.main_count;
      out_d.last       = 1'b1;
    end
    if (out_d.status == utf8dc_pkg::StOk) begin
      if (out_d.code_point >= utf8dc_pkg::AsciiZero &&
          out_d.code_point <= utf8dc_pkg::AsciiNine) begin
        out_d.is_digit    = 1'b1;
        out_d.digit_value = out_d.code_point[3:0];
      end else if (utf8dc_pkg::is_scalar(zero_q) && out_d.code_point >= zero_q &&
                   diff <= 21'd9) begin
        out_d.is_digit    = 1'b1;
        out_d.digit_value = diff[3:0];
      end
    end
    if (load) begin
      valid_d = 1'b1;
      if (sel_first && rec_i.main_v) begin
        phase_d = 1'b1;
      end else begin
        phase_d   = 1'b0;
        rec_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q  <= utf8dc_pkg::ZeroReset;
      phase_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        zero_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign empty_o  = !valid_q;
  assign result_o = out_q;

  a_phase_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (!rec_empty_i && rec_i.first_v && rec_i.main_v))
    else $error("split record lost from queue head");

  a_digit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_q.is_digit) |->
      (out_q.status == utf8dc_pkg::StOk && out_q.digit_value <= 4'd9))
    else $error("digit flagged on bad word");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_q.status != utf8dc_pkg::StOk) |->
      (out_q.code_point == '0 && !out_q.is_digit && out_q.digit_value == '0))
    else $error("error word carries data");

  a_first_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && sel_first && rec_i.main_v) |=> (valid_q && !out_q.last && phase_q))
    else $error("broken-sequence word marked last");

endmodule
